// ----- design/assert_macros.svh -----
// assertion macros used by the responder top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequence that must hold on the clock edge after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sdspi_pkg.sv -----
// types, constants and reply byte lookup for the sd card spi-mode responder
`default_nettype none

package sdspi_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int REPLY_DEPTH   = 32;
    localparam int COMMAND_BYTES = 6;

    localparam int CNT_W    = $clog2(COMMAND_BYTES + 1);
    localparam int RLEN_W   = $clog2(REPLY_DEPTH + 1);
    localparam int RPOS_W   = $clog2(REPLY_DEPTH);
    localparam int DPOS_W   = $clog2(BLOCK_BYTES + 4);
    localparam int HDR_BITS = 8 * (COMMAND_BYTES - 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
    localparam logic [5:0] CMD_SEND_CID     = 6'd10;
    localparam logic [5:0] CMD_STOP_TRAN    = 6'd12;
    localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
    localparam logic [5:0] CMD_APP_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP_CMD      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR     = 6'd58;
    localparam logic [5:0] CMD_CRC_ON_OFF   = 6'd59;

    localparam logic [5:0] CMD_INDEX_MASK = 6'h3F;

    // response bytes and tokens
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_ILLEGAL  = 8'h04;
    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] BYTE_IDLE   = 8'hFF;

    localparam logic [31:0] OCR_RESET       = 32'h40FF_8000;
    localparam logic [31:0] IF_COND_ECHO    = 32'h0000_0100;

    // reply lengths in bytes
    localparam logic [RLEN_W-1:0] LEN_R1     = RLEN_W'(1);
    localparam logic [RLEN_W-1:0] LEN_STATUS = RLEN_W'(2);
    localparam logic [RLEN_W-1:0] LEN_WORD   = RLEN_W'(5);
    localparam logic [RLEN_W-1:0] LEN_TABLE  = RLEN_W'(20);

    // register table replies: r1, start token, 16 bytes, two crc bytes
    localparam int TABLE_HEAD = 2;
    localparam int TABLE_END  = TABLE_HEAD + 16;

    localparam logic [7:0] CSD_TABLE [16] = '{
        8'h40, 8'h0E, 8'h00, 8'h32, 8'h5B, 8'h59, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7F, 8'h80, 8'h0A, 8'h40, 8'h00, 8'hAF
    };
    localparam logic [7:0] CID_TABLE [16] = '{
        8'h03, 8'h59, 8'h45, 8'h4C, 8'h59, 8'h41, 8'h48, 8'h20,
        8'h26, 8'h09, 8'h13, 8'h12, 8'h34, 8'h56, 8'h78, 8'h01
    };

    typedef enum logic [1:0] {
        ACT_BYTE     = 2'd0,
        ACT_SELECT   = 2'd1,
        ACT_DESELECT = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        RK_R1     = 3'd0,
        RK_WORD   = 3'd1,
        RK_STATUS = 3'd2,
        RK_CSD    = 3'd3,
        RK_CID    = 3'd4
    } t_reply_kind;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_driven;
        logic       card_idle;
        logic       card_ready;
        logic       crc_checking;
    } t_result;

    // byte at a given position of the queued reply
    function automatic logic [7:0] reply_byte(
        input t_reply_kind       kind,
        input logic [7:0]        r1,
        input logic [31:0]       word,
        input logic [RPOS_W-1:0] pos
    );
        logic [3:0] idx;
        logic [7:0] b;
        idx = 4'(pos - RPOS_W'(TABLE_HEAD));
        b   = BYTE_IDLE;
        case (kind)
            RK_R1: begin
                b = r1;
            end
            RK_WORD: begin
                case (pos)
                    RPOS_W'(0): b = r1;
                    RPOS_W'(1): b = word[31:24];
                    RPOS_W'(2): b = word[23:16];
                    RPOS_W'(3): b = word[15:8];
                    RPOS_W'(4): b = word[7:0];
                    default:    b = BYTE_IDLE;
                endcase
            end
            RK_STATUS: begin
                b = R1_READY;
            end
            RK_CSD, RK_CID: begin
                if (pos == RPOS_W'(0)) begin
                    b = R1_READY;
                end else if (pos == RPOS_W'(1)) begin
                    b = TOKEN_START;
                end else if (pos < RPOS_W'(TABLE_END)) begin
                    b = (kind == RK_CSD) ? CSD_TABLE[idx] : CID_TABLE[idx];
                end else begin
                    b = BYTE_IDLE;
                end
            end
            default: begin
                b = BYTE_IDLE;
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/sdspi_core.sv -----
// command parser, reply sequencer and data stream of the sd card spi-mode responder
`default_nettype none

module sdspi_core
    import sdspi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_action     i_action,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cs_selected,
    input  wire logic [31:0] i_ocr_word,
    output t_result          o_result
);

    logic [HDR_BITS-1:0] r_hdr,        n_hdr;
    logic [CNT_W-1:0]    r_cmd_count,  n_cmd_count;
    t_reply_kind         r_reply_kind, n_reply_kind;
    logic [7:0]          r_reply_r1,   n_reply_r1;
    logic [31:0]         r_reply_word, n_reply_word;
    logic [RLEN_W-1:0]   r_reply_len,  n_reply_len;
    logic [RLEN_W-1:0]   r_reply_pos,  n_reply_pos;
    logic                r_app_prefix, n_app_prefix;
    logic                r_idle,       n_idle;
    logic                r_ready,      n_ready;
    logic                r_crc,        n_crc;
    logic [DPOS_W-1:0]   r_data_pos,   n_data_pos;
    logic                r_data_active, n_data_active;

    logic [5:0]        cmd;
    logic [31:0]       arg;
    logic [7:0]        status_r1;
    logic [DPOS_W-1:0] data_idx;
    logic [7:0]        tx;
    logic              driven;

    assign cmd       = r_hdr[HDR_BITS-3 -: 6] & CMD_INDEX_MASK;
    assign arg       = r_hdr[31:0];
    assign status_r1 = r_idle ? R1_IDLE : R1_READY;

    always_comb begin
        n_hdr         = r_hdr;
        n_cmd_count   = r_cmd_count;
        n_reply_kind  = r_reply_kind;
        n_reply_r1    = r_reply_r1;
        n_reply_word  = r_reply_word;
        n_reply_len   = r_reply_len;
        n_reply_pos   = r_reply_pos;
        n_app_prefix  = r_app_prefix;
        n_idle        = r_idle;
        n_ready       = r_ready;
        n_crc         = r_crc;
        n_data_pos    = r_data_pos;
        n_data_active = r_data_active;
        data_idx      = r_data_pos;
        tx            = BYTE_IDLE;
        driven        = 1'b0;

        case (i_action)
            ACT_BYTE: begin
                if (r_cmd_count < CNT_W'(COMMAND_BYTES)) begin
                    n_hdr       = {r_hdr[HDR_BITS-9:0], i_rx_byte};
                    n_cmd_count = r_cmd_count + 1'b1;
                    if (r_cmd_count == CNT_W'(COMMAND_BYTES - 1)) begin
                        // last byte of the frame: decode and queue the answer
                        n_reply_pos   = '0;
                        n_data_active = 1'b0;
                        n_reply_kind  = RK_R1;
                        n_reply_len   = LEN_R1;
                        n_reply_word  = i_ocr_word;
                        n_reply_r1    = R1_ILLEGAL;
                        if (cmd == CMD_APP_CMD) begin
                            n_app_prefix = 1'b1;
                            n_reply_r1   = status_r1;
                        end else if (cmd == CMD_APP_OP_COND && r_app_prefix) begin
                            n_app_prefix = 1'b0;
                            n_idle       = 1'b0;
                            n_ready      = 1'b1;
                            n_reply_r1   = R1_READY;
                        end else begin
                            n_app_prefix = 1'b0;
                            case (cmd)
                                CMD_GO_IDLE: begin
                                    n_idle     = 1'b1;
                                    n_ready    = 1'b0;
                                    n_reply_r1 = R1_IDLE;
                                end
                                CMD_SEND_IF_COND: begin
                                    n_reply_kind = RK_WORD;
                                    n_reply_len  = LEN_WORD;
                                    n_reply_r1   = R1_IDLE;
                                    n_reply_word = IF_COND_ECHO | {24'h0, arg[7:0]};
                                end
                                CMD_READ_OCR: begin
                                    n_reply_kind = RK_WORD;
                                    n_reply_len  = LEN_WORD;
                                    n_reply_r1   = status_r1;
                                end
                                CMD_CRC_ON_OFF: begin
                                    n_crc      = arg[0];
                                    n_reply_r1 = status_r1;
                                end
                                CMD_SET_BLOCKLEN: begin
                                    n_reply_r1 = (arg == 32'(BLOCK_BYTES)) ? R1_READY
                                                                           : R1_ILLEGAL;
                                end
                                CMD_READ_SINGLE: begin
                                    n_data_pos    = '0;
                                    n_data_active = 1'b1;
                                    n_reply_r1    = R1_READY;
                                end
                                CMD_WRITE_SINGLE, CMD_STOP_TRAN: begin
                                    n_reply_r1 = R1_READY;
                                end
                                CMD_SEND_STATUS: begin
                                    n_reply_kind = RK_STATUS;
                                    n_reply_len  = LEN_STATUS;
                                    n_reply_r1   = R1_READY;
                                end
                                CMD_SEND_CSD: begin
                                    n_reply_kind = RK_CSD;
                                    n_reply_len  = LEN_TABLE;
                                    n_reply_r1   = R1_READY;
                                end
                                CMD_SEND_CID: begin
                                    n_reply_kind = RK_CID;
                                    n_reply_len  = LEN_TABLE;
                                    n_reply_r1   = R1_READY;
                                end
                                default: begin
                                    n_reply_r1 = R1_ILLEGAL;
                                end
                            endcase
                        end
                    end
                end

                if (i_cs_selected) begin
                    driven = 1'b1;
                    if (n_reply_pos < n_reply_len) begin
                        tx = reply_byte(n_reply_kind, n_reply_r1, n_reply_word,
                                        n_reply_pos[RPOS_W-1:0]);
                        n_reply_pos = n_reply_pos + 1'b1;
                    end else if (n_data_active) begin
                        if (n_data_pos == '0) begin
                            tx         = TOKEN_START;
                            n_data_pos = DPOS_W'(1);
                        end else if (n_data_pos <= DPOS_W'(BLOCK_BYTES)) begin
                            data_idx   = n_data_pos - 1'b1;
                            tx         = 8'(data_idx);
                            n_data_pos = n_data_pos + 1'b1;
                        end else begin
                            // crc bytes of the data block
                            n_data_pos = n_data_pos + 1'b1;
                            if (n_data_pos >= DPOS_W'(BLOCK_BYTES + 3)) begin
                                n_data_active = 1'b0;
                            end
                        end
                    end
                    if (n_reply_len != '0 && n_reply_pos >= n_reply_len && !n_data_active) begin
                        n_reply_len = '0;
                        n_reply_pos = '0;
                        n_cmd_count = '0;
                    end
                end
            end
            ACT_SELECT, ACT_DESELECT: begin
                n_cmd_count   = '0;
                n_reply_len   = '0;
                n_reply_pos   = '0;
                n_data_active = 1'b0;
                driven        = (i_action == ACT_SELECT);
            end
            default: begin
                driven = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_count   <= '0;
            r_reply_len   <= '0;
            r_reply_pos   <= '0;
            r_app_prefix  <= 1'b0;
            r_idle        <= 1'b1;
            r_ready       <= 1'b0;
            r_crc         <= 1'b0;
            r_data_pos    <= '0;
            r_data_active <= 1'b0;
        end else if (i_accept) begin
            r_cmd_count   <= n_cmd_count;
            r_reply_len   <= n_reply_len;
            r_reply_pos   <= n_reply_pos;
            r_app_prefix  <= n_app_prefix;
            r_idle        <= n_idle;
            r_ready       <= n_ready;
            r_crc         <= n_crc;
            r_data_pos    <= n_data_pos;
            r_data_active <= n_data_active;
        end
    end

    // command header and reply payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr        <= n_hdr;
            r_reply_kind <= n_reply_kind;
            r_reply_r1   <= n_reply_r1;
            r_reply_word <= n_reply_word;
        end
    end

    always_comb begin
        o_result.tx_byte      = tx;
        o_result.tx_driven    = driven;
        o_result.card_idle    = n_idle;
        o_result.card_ready   = n_ready;
        o_result.crc_checking = n_crc;
    end

endmodule

`default_nettype wire

// ----- design/sd_card_spi_mode_responder_top.sv -----
// sd card spi-mode responder: one event per transfer in, one miso byte and card status out.
// each accepted event (byte exchanged, chip select asserted or released) is decoded in the
// cycle it is taken and its result is loaded into the output register, so one event is
// accepted per clock while the output side keeps up and the result appears in the cycle
// after acceptance. the input side stalls only while the output register holds a result
// that the downstream has not yet taken. the operating conditions word sits at byte
// address 0 of the apb port; the user must write it between commands; not enforced.
`default_nettype none

module sd_card_spi_mode_responder_top
    import sdspi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // rx_byte[7:0], cs_selected[8], zeros
    input  wire logic [1:0]           i_s_tuser,   // action[1:0]
    // master side
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tx_byte[7:0], tx_driven[8], card_idle[9], card_ready[10], crc_checking[11], zeros
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic        s_accept;
    logic        r_out_valid, n_out_valid;
    t_result     r_out;
    t_result     core_result;
    logic [31:0] r_ocr;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    sdspi_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_action      (t_action'(i_s_tuser)),
        .i_rx_byte     (i_s_tdata[7:0]),
        .i_cs_selected (i_s_tdata[8]),
        .i_ocr_word    (r_ocr),
        .o_result      (core_result)
    );

    assign n_out_valid = s_accept || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out.crc_checking, r_out.card_ready, r_out.card_idle,
                         r_out.tx_driven, r_out.tx_byte};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocr <= OCR_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_ocr <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : r_ocr;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_idle_ready_exclusive,
        !(o_m_tvalid && o_m_tdata[9] && o_m_tdata[10]),
        "card reported idle and ready at once")
    `ASSERT_ALWAYS(a_undriven_is_idle_byte,
        !(o_m_tvalid && !o_m_tdata[8] && o_m_tdata[7:0] != BYTE_IDLE),
        "undriven miso byte is not the idle byte")
    `ASSERT_NEXT(a_deselect_releases_miso,
        s_accept && i_s_tuser == ACT_DESELECT,
        o_m_tvalid && !o_m_tdata[8] && o_m_tdata[7:0] == BYTE_IDLE,
        "chip select release did not release miso")

endmodule

`default_nettype wire

// ----- verif/miso_checker.sv -----
// checker for the sd card spi-mode responder: predicts each miso result and compares it
module miso_checker
    import sdspi_pkg::*;
#(
    parameter logic [2:0] OCR_ADDR = 3'd0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // rx_byte[7:0], cs_selected[8], zeros
    input  logic [1:0]           i_s_tuser,   // action[1:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // tx_byte[7:0], tx_driven[8], card_idle[9], card_ready[10], crc_checking[11], zeros
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic [31:0]          i_prdata,
    input  logic                 i_pready,
    output int                   o_pending,
    output int                   o_fail_count
);

    logic [31:0]       ocr_val;
    logic [7:0]        cmd_mem [COMMAND_BYTES];
    logic [CNT_W-1:0]  cmd_cnt;
    logic [7:0]        rep_mem [REPLY_DEPTH];
    logic [RLEN_W-1:0] rep_len;
    logic [RLEN_W-1:0] rep_pos;
    logic              app_seen;
    logic              idle_f;
    logic              ready_f;
    logic              crc_f;
    logic [DPOS_W-1:0] data_pos;
    logic              data_on;
    t_result           card_answers [$];
    int                fails = 0;

    function automatic void clear_cmd();
        cmd_cnt = '0;
        foreach (cmd_mem[i]) cmd_mem[i] = '0;
    endfunction

    function automatic void clear_reply();
        rep_len = '0;
        rep_pos = '0;
    endfunction

    function automatic void power_on();
        ocr_val = OCR_RESET;
        clear_cmd();
        foreach (rep_mem[i]) rep_mem[i] = '0;
        clear_reply();
        app_seen = 1'b0;
        idle_f   = 1'b1;
        ready_f  = 1'b0;
        crc_f    = 1'b0;
        data_pos = '0;
        data_on  = 1'b0;
    endfunction

    // bytes past the end of the reply store are dropped
    function automatic void push_reply(input logic [7:0] v);
        if (rep_len < RLEN_W'(REPLY_DEPTH)) begin
            rep_mem[rep_len[RPOS_W-1:0]] = v;
            rep_len++;
        end
    endfunction

    function automatic void push_word(input logic [31:0] w);
        push_reply(w[31:24]);
        push_reply(w[23:16]);
        push_reply(w[15:8]);
        push_reply(w[7:0]);
    endfunction

    function automatic void push_table(input logic is_csd);
        push_reply(R1_READY);
        push_reply(TOKEN_START);
        for (int i = 0; i < 16; i++) push_reply(is_csd ? CSD_TABLE[i] : CID_TABLE[i]);
        push_reply(BYTE_IDLE);
        push_reply(BYTE_IDLE);
    endfunction

    function automatic void decode_command();
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [7:0]  r1;
        idx = cmd_mem[0][5:0] & CMD_INDEX_MASK;
        arg = {cmd_mem[1], cmd_mem[2], cmd_mem[3], cmd_mem[4]};
        r1  = idle_f ? R1_IDLE : R1_READY;
        clear_reply();
        data_on = 1'b0;
        if (idx == CMD_APP_CMD) begin
            app_seen = 1'b1;
            push_reply(r1);
        end else if (idx == CMD_APP_OP_COND && app_seen) begin
            app_seen = 1'b0;
            idle_f   = 1'b0;
            ready_f  = 1'b1;
            push_reply(R1_READY);
        end else begin
            app_seen = 1'b0;
            case (idx)
                CMD_GO_IDLE: begin
                    idle_f  = 1'b1;
                    ready_f = 1'b0;
                    push_reply(R1_IDLE);
                end
                CMD_SEND_IF_COND: begin
                    push_reply(R1_IDLE);
                    push_word(IF_COND_ECHO | {24'h0, arg[7:0]});
                end
                CMD_READ_OCR: begin
                    push_reply(r1);
                    push_word(ocr_val);
                end
                CMD_CRC_ON_OFF: begin
                    crc_f = arg[0];
                    push_reply(r1);
                end
                CMD_SET_BLOCKLEN: begin
                    push_reply(arg == 32'(BLOCK_BYTES) ? R1_READY : R1_ILLEGAL);
                end
                CMD_READ_SINGLE: begin
                    data_pos = '0;
                    data_on  = 1'b1;
                    push_reply(R1_READY);
                end
                CMD_WRITE_SINGLE, CMD_STOP_TRAN: begin
                    push_reply(R1_READY);
                end
                CMD_SEND_STATUS: begin
                    push_reply(R1_READY);
                    push_reply(R1_READY);
                end
                CMD_SEND_CSD: begin
                    push_table(1'b1);
                end
                CMD_SEND_CID: begin
                    push_table(1'b0);
                end
                default: begin
                    push_reply(R1_ILLEGAL);
                end
            endcase
        end
    endfunction

    // reply first, then the data block: token, counting bytes, two crc bytes
    function automatic logic [7:0] next_miso();
        logic [7:0] v;
        v = BYTE_IDLE;
        if (rep_pos < rep_len) begin
            v = rep_mem[rep_pos[RPOS_W-1:0]];
            rep_pos++;
        end else if (data_on) begin
            if (data_pos == '0) begin
                data_pos = DPOS_W'(1);
                v = TOKEN_START;
            end else if (data_pos <= DPOS_W'(BLOCK_BYTES)) begin
                v = 8'(data_pos - DPOS_W'(1));
                data_pos++;
            end else begin
                data_pos++;
                if (data_pos >= DPOS_W'(BLOCK_BYTES + 3)) data_on = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic t_result card_step(input logic [1:0] act, input logic [7:0] rx,
                                          input logic sel);
        t_result r;
        r.tx_byte   = BYTE_IDLE;
        r.tx_driven = 1'b0;
        if (act == ACT_BYTE) begin
            if (cmd_cnt < CNT_W'(COMMAND_BYTES)) begin
                cmd_mem[cmd_cnt] = rx;
                cmd_cnt++;
                if (cmd_cnt == CNT_W'(COMMAND_BYTES)) decode_command();
            end
            if (sel) begin
                r.tx_byte   = next_miso();
                r.tx_driven = 1'b1;
                if (rep_len != '0 && rep_pos >= rep_len && !data_on) begin
                    clear_reply();
                    clear_cmd();
                end
            end
        end else if (act == ACT_SELECT || act == ACT_DESELECT) begin
            clear_cmd();
            clear_reply();
            data_on     = 1'b0;
            r.tx_driven = (act == ACT_SELECT);
        end
        r.card_idle    = idle_f;
        r.card_ready   = ready_f;
        r.crc_checking = crc_f;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    initial power_on();

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            power_on();
            card_answers.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == OCR_ADDR) begin
                if (i_pwrite) begin
                    ocr_val = i_pwdata;
                end else begin
                    check_field("ocr read", ocr_val, i_prdata);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                card_answers.push_back(card_step(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (card_answers.size() == 0) begin
                    $display("%0t unexpected transfer expected none actual %0h", $time,
                             i_m_tdata);
                    fails++;
                end else begin
                    want             = card_answers.pop_front();
                    got.tx_byte      = i_m_tdata[7:0];
                    got.tx_driven    = i_m_tdata[8];
                    got.card_idle    = i_m_tdata[9];
                    got.card_ready   = i_m_tdata[10];
                    got.crc_checking = i_m_tdata[11];
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("tx_driven", want.tx_driven, got.tx_driven);
                    check_field("card_idle", want.card_idle, got.card_idle);
                    check_field("card_ready", want.card_ready, got.card_ready);
                    check_field("crc_checking", want.crc_checking, got.crc_checking);
                end
            end
        end
        o_pending    <= card_answers.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the sd card spi-mode responder: stimulus, configuration and verdict
module tb;
    import sdspi_pkg::*;

    localparam logic [2:0] OCR_ADDR    = 3'd0;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 quiet = 1'b0;
    int                   pending;
    int                   fail_count;
    int                   sent = 0;
    int                   cycles = 0;

    sd_card_spi_mode_responder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    miso_checker #(.OCR_ADDR(OCR_ADDR)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= quiet || ($urandom_range(99) >= 23);
    end

    // one transfer on the slave side, entered and left at a falling edge
    task automatic send_event(input logic [1:0] act, input logic [7:0] rx, input logic sel);
        while (!quiet && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, sel, rx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= OCR_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_ocr(input logic [31:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    // release chip select and let every result drain
    task automatic settle();
        send_event(ACT_DESELECT, 8'hFF, 1'b0);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // bytes still to clock out after the one that completes the command
    function automatic int reply_span(input logic [5:0] idx);
        case (idx)
            CMD_SEND_IF_COND, CMD_READ_OCR: return int'(LEN_WORD) - 1;
            CMD_SEND_STATUS:                return int'(LEN_STATUS) - 1;
            CMD_SEND_CSD, CMD_SEND_CID:     return int'(LEN_TABLE) - 1;
            CMD_READ_SINGLE:                return BLOCK_BYTES + 3;
            default:                        return 0;
        endcase
    endfunction

    task automatic issue_command(input logic [7:0] head, input logic [31:0] arg,
                                 input int reads);
        send_event(ACT_BYTE, head, 1'b1);
        send_event(ACT_BYTE, arg[31:24], 1'b1);
        send_event(ACT_BYTE, arg[23:16], 1'b1);
        send_event(ACT_BYTE, arg[15:8], 1'b1);
        send_event(ACT_BYTE, arg[7:0], 1'b1);
        send_event(ACT_BYTE, {7'($urandom_range(127)), 1'b1}, 1'b1);
        for (int i = 0; i < reads; i++) begin
            // deselected byte in the middle of a reply
            if ($urandom_range(19) == 0) send_event(ACT_BYTE, 8'($urandom_range(255)), 1'b0);
            send_event(ACT_BYTE, ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'hFF,
                       1'b1);
        end
    endtask

    task automatic plain_command(input logic [5:0] idx, input logic [31:0] arg);
        issue_command({2'b01, idx}, arg, reply_span(idx));
    endtask

    function automatic logic [5:0] pick_command();
        case ($urandom_range(15))
            0:       return CMD_GO_IDLE;
            1:       return CMD_SEND_IF_COND;
            2:       return CMD_SEND_CSD;
            3:       return CMD_SEND_CID;
            4:       return CMD_STOP_TRAN;
            5:       return CMD_SEND_STATUS;
            6:       return CMD_SET_BLOCKLEN;
            7:       return ($urandom_range(3) == 0) ? CMD_READ_SINGLE : CMD_APP_CMD;
            8:       return CMD_WRITE_SINGLE;
            9:       return CMD_APP_OP_COND;
            10:      return CMD_APP_CMD;
            11:      return CMD_READ_OCR;
            12:      return CMD_CRC_ON_OFF;
            13, 14:  return 6'($urandom_range(63));
            default: return CMD_APP_CMD;
        endcase
    endfunction

    task automatic random_sequence();
        int          pick;
        int          reads;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [7:0]  head;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_event(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (pick < 14) begin
            // command cut short by a chip select edge
            repeat ($urandom_range(1, 5)) begin
                send_event(ACT_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            send_event($urandom_range(1) ? ACT_SELECT : ACT_DESELECT, 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end else begin
            if ($urandom_range(9) < 6) send_event(ACT_SELECT, 8'hFF, 1'b1);
            idx = pick_command();
            arg = $urandom;
            if (idx == CMD_SET_BLOCKLEN && $urandom_range(1) == 1) arg = 32'(BLOCK_BYTES);
            if (idx == CMD_APP_CMD && $urandom_range(1) == 1) begin
                plain_command(CMD_APP_CMD, $urandom);
                idx = CMD_APP_OP_COND;
            end
            head  = {($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b01, idx};
            reads = reply_span(idx);
            if (idx == CMD_READ_SINGLE ? $urandom_range(1) == 0 : $urandom_range(9) == 0) begin
                reads = $urandom_range((reads + 3 < 40) ? reads + 3 : 40);
                issue_command(head, arg, reads);
                send_event($urandom_range(1) ? ACT_SELECT : ACT_DESELECT, 8'hFF, 1'b1);
            end else begin
                issue_command(head, arg, reads);
            end
        end
    endtask

    task automatic random_phase(input int count);
        int stop;
        stop = sent + count;
        while (sent < stop) random_sequence();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_access(1'b0, '0);

        send_event(ACT_SELECT, 8'h00, 1'b1);
        send_event(ACT_UNUSED, 8'hA5, 1'b1);
        send_event(ACT_BYTE, 8'h40, 1'b0);
        send_event(ACT_DESELECT, 8'hFF, 1'b0);
        send_event(ACT_SELECT, 8'hFF, 1'b1);
        plain_command(CMD_GO_IDLE, 32'h0000_0000);
        plain_command(CMD_SEND_IF_COND, 32'h0000_01AA);
        plain_command(CMD_APP_OP_COND, 32'h4000_0000);
        plain_command(CMD_READ_OCR, 32'hFFFF_FFFF);
        plain_command(CMD_APP_CMD, 32'h0000_0000);
        plain_command(CMD_APP_OP_COND, 32'h4000_0000);
        plain_command(CMD_CRC_ON_OFF, 32'h0000_0001);
        plain_command(CMD_SET_BLOCKLEN, 32'(BLOCK_BYTES));
        plain_command(CMD_SET_BLOCKLEN, 32'hFFFF_FFFF);
        plain_command(CMD_SEND_CSD, 32'h0000_0000);
        plain_command(CMD_SEND_CID, 32'h0000_0000);
        plain_command(CMD_STOP_TRAN, 32'h0000_0000);
        plain_command(CMD_SEND_STATUS, 32'h0000_0000);
        plain_command(CMD_WRITE_SINGLE, 32'h0000_0000);
        plain_command(CMD_CRC_ON_OFF, 32'h0000_0000);
        issue_command(8'hFF, 32'hFFFF_FFFF, 0);
        plain_command(CMD_READ_SINGLE, 32'h0000_0000);
        plain_command(CMD_GO_IDLE, 32'h0000_0000);

        settle();
        program_ocr(32'hFFFF_FFFF);
        random_phase(275);

        settle();
        program_ocr(32'h0000_0000);
        quiet = 1'b1;
        random_phase(150);
        quiet = 1'b0;
        random_phase(100);

        settle();
        program_ocr($urandom);
        random_phase(275);

        settle();
        program_ocr(OCR_RESET);
        random_phase(275);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
